>>> rtl/reversible_deque_defines.svh
// ----------------------------------------------------------------------------
// Reversible deque assertion macros
// Clocked property checks used by the deque RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef REVERSIBLE_DEQUE_DEFINES_SVH
`define REVERSIBLE_DEQUE_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked at every edge outside reset.
`define RDQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked at every edge, reset included.
`define RDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDQ_ASSERT(label, clk, rst, prop, msg)
`define RDQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/rdq_pkg.sv
// ----------------------------------------------------------------------------
// Reversible deque package
// Word types, command and status codes, and sizes shared by the deque RTL.
// ----------------------------------------------------------------------------
package rdq_pkg;

   // Default geometry of the element store.
   localparam int DEPTH_DEF      = 64;
   localparam int DATA_WIDTH_DEF = 16;

   // Field widths of the request and response words.
   localparam int CMD_W    = 4;
   localparam int VALUE_W  = 16;
   localparam int DATA_W   = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Command queue between the front and back ends.
   localparam int CQ_DEPTH = 2;
   localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUT_FRONT  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_PUT_BACK   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_TAKE_FRONT = 4'd2;
   localparam logic [CMD_W-1:0] CMD_TAKE_BACK  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 4'd4;
   localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_REVERSE    = 4'd6;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd7;
   localparam logic [CMD_W-1:0] CMD_DUMP       = 4'd8;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } rsp_word_type;

   // Operation classes decoded by the front end.
   typedef enum logic [2:0] {
      OP_PUSH,
      OP_POP,
      OP_PEEK,
      OP_REVERSE,
      OP_CLEAR,
      OP_DUMP,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               at_front;
      logic [VALUE_W-1:0] value;
   } op_word_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_POP_OUT,
      BK_DUMP_RD,
      BK_DUMP_OUT
   } back_state_type;

endpackage

>>> rtl/rdq_front.sv
// ----------------------------------------------------------------------------
// Reversible deque front end
// Accepts request words, decodes the command and registers the decoded word.
// ----------------------------------------------------------------------------
module rdq_front import rdq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         op_valid,
   input  logic         op_ready,
   output op_word_type  op_word
);

   logic        front_valid_ff, front_valid_in;
   op_word_type front_word_ff, front_word_in;
   op_word_type decoded;
   logic        take;

   // Decode the command into an operation class and its logical end.
   always_comb begin
      decoded.at_front = ~req_word.cmd[0];
      decoded.value    = req_word.value;
      unique case (req_word.cmd)
         CMD_PUT_FRONT, CMD_PUT_BACK:   decoded.op = OP_PUSH;
         CMD_TAKE_FRONT, CMD_TAKE_BACK: decoded.op = OP_POP;
         CMD_PEEK_FRONT, CMD_PEEK_BACK: decoded.op = OP_PEEK;
         CMD_REVERSE:                   decoded.op = OP_REVERSE;
         CMD_CLEAR:                     decoded.op = OP_CLEAR;
         CMD_DUMP:                      decoded.op = OP_DUMP;
         default:                       decoded.op = OP_NOP;
      endcase
   end

   // The stage takes a new word when empty or when its word moves on.
   assign req_ready = ~front_valid_ff | op_ready;
   assign take      = req_valid & req_ready;

   always_comb begin
      front_valid_in = take | (front_valid_ff & ~op_ready);
      front_word_in  = take ? decoded : front_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_word_ff <= front_word_in;
   end

   assign op_valid = front_valid_ff;
   assign op_word  = front_word_ff;

endmodule

>>> rtl/rdq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Reversible deque command queue
// Short queue of decoded words between the front and back ends.
// ----------------------------------------------------------------------------
`include "reversible_deque_defines.svh"

module rdq_cmd_fifo import rdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  op_word_type in_word,
   output logic        out_valid,
   input  logic        out_ready,
   output op_word_type out_word
);

   localparam logic [CQ_PTR_W-1:0] LAST_PTR = CQ_PTR_W'(CQ_DEPTH - 1);
   localparam logic [CQ_CNT_W-1:0] FULL_CNT = CQ_CNT_W'(CQ_DEPTH);

   op_word_type         entry_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0] count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_word  = entry_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_word;
      end
   end

   `RDQ_ASSERT(a_cq_count_bound, clock, reset, count_ff <= FULL_CNT, "command queue overfilled")

endmodule

>>> rtl/rdq_back.sv
// ----------------------------------------------------------------------------
// Reversible deque back end
// Holds the ring store and its pointers, executes commands, drives responses.
// ----------------------------------------------------------------------------
`include "reversible_deque_defines.svh"

module rdq_back import rdq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   input  op_word_type  cmd_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [IW-1:0] LAST_SLOT  = IW'(DEPTH - 1);

   // Ring store and its registered read port.
   logic [DATA_WIDTH-1:0] store_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  mem_we, mem_re;
   logic [IW-1:0]         mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata;

   back_state_type state_ff, state_in;
   logic [IW-1:0]  head_ff, head_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic           rev_ff, rev_in;
   logic [CW-1:0]  dump_n_ff, dump_n_in;
   logic [CW-1:0]  dump_i_ff, dump_i_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_word_type   rsp_word_ff, rsp_word_in;

   logic           out_free, emit, phys_front, dump_last;
   rsp_word_type   emit_word;
   logic [IW-1:0]  head_dec, head_inc;
   logic [CW-1:0]  dump_off;

   // Physical slot at an offset from a base slot, wrapped around the ring.
   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign phys_front = cmd_word.at_front ^ rev_ff;
   assign head_dec   = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign head_inc   = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign dump_off   = rev_ff ? (dump_n_ff - 1'b1 - dump_i_ff) : dump_i_ff;
   assign dump_last  = (dump_i_ff == dump_n_ff - 1'b1);

   // Command sequencer: most commands finish in idle; pops and peeks read, then
   // emit from pop-out; each dumped element passes a read and an emit state.
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      rev_in    = rev_ff;
      dump_n_in = dump_n_ff;
      dump_i_in = dump_i_ff;
      mem_we    = 1'b0;
      mem_waddr = slot_of(head_ff, fill_ff);
      mem_wdata = DATA_WIDTH'(cmd_word.value);
      mem_re    = 1'b0;
      mem_raddr = head_ff;
      emit      = 1'b0;
      emit_word = '0;
      cmd_ready = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_ready = out_free;
            if (cmd_valid && out_free) begin
               emit_word.last = 1'b1;
               unique case (cmd_word.op)
                  OP_PUSH: begin
                     emit = 1'b1;
                     if (fill_ff == FULL_COUNT) begin
                        emit_word.status = ST_FULL;
                        emit_word.count  = COUNT_W'(fill_ff);
                     end else begin
                        mem_we  = 1'b1;
                        fill_in = fill_ff + 1'b1;
                        if (phys_front) begin
                           mem_waddr = head_dec;
                           head_in   = head_dec;
                        end
                        emit_word.status = ST_OK;
                        emit_word.count  = COUNT_W'(fill_ff + 1'b1);
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (fill_ff == '0) begin
                        emit             = 1'b1;
                        emit_word.status = ST_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = phys_front ? head_ff : slot_of(head_ff, fill_ff - 1'b1);
                        state_in  = BK_POP_OUT;
                        if (cmd_word.op == OP_POP) begin
                           fill_in = fill_ff - 1'b1;
                           if (phys_front) begin
                              head_in = head_inc;
                           end
                        end
                     end
                  end
                  OP_REVERSE: begin
                     emit            = 1'b1;
                     rev_in          = ~rev_ff;
                     emit_word.count = COUNT_W'(fill_ff);
                  end
                  OP_CLEAR: begin
                     emit    = 1'b1;
                     fill_in = '0;
                  end
                  OP_DUMP: begin
                     if (fill_ff == '0) begin
                        emit             = 1'b1;
                        emit_word.status = ST_EMPTY;
                     end else begin
                        dump_n_in = fill_ff;
                        dump_i_in = '0;
                        fill_in   = '0;
                        state_in  = BK_DUMP_RD;
                     end
                  end
                  default: begin
                     emit            = 1'b1;
                     emit_word.count = COUNT_W'(fill_ff);
                  end
               endcase
            end
         end
         BK_POP_OUT: begin
            if (out_free) begin
               emit             = 1'b1;
               emit_word.data   = DATA_W'(rd_data_ff);
               emit_word.status = ST_OK;
               emit_word.count  = COUNT_W'(fill_ff);
               emit_word.last   = 1'b1;
               state_in         = BK_IDLE;
            end
         end
         BK_DUMP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = slot_of(head_ff, dump_off);
            state_in  = BK_DUMP_OUT;
         end
         BK_DUMP_OUT: begin
            if (out_free) begin
               emit             = 1'b1;
               emit_word.data   = DATA_W'(rd_data_ff);
               emit_word.status = ST_OK;
               emit_word.last   = dump_last;
               dump_i_in        = dump_i_ff + 1'b1;
               state_in         = dump_last ? BK_IDLE : BK_DUMP_RD;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Response register: a new word loads when the old one is gone or taken.
   always_comb begin
      rsp_valid_in = emit | (rsp_valid_ff & ~rsp_ready);
      rsp_word_in  = emit ? emit_word : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dump_n_ff   <= dump_n_in;
      dump_i_ff   <= dump_i_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Ring store write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `RDQ_ASSERT(a_fill_bound, clock, reset, fill_ff <= FULL_COUNT, "fill count beyond depth")
   `RDQ_ASSERT(a_dump_walk, clock, reset, (state_ff == BK_DUMP_RD || state_ff == BK_DUMP_OUT) |-> (fill_ff == '0 && dump_i_ff < dump_n_ff), "dump walk out of range")
   `RDQ_ASSERT(a_reverse_flips, clock, reset, (cmd_valid && cmd_ready && cmd_word.op == OP_REVERSE) |=> (rev_ff != $past(rev_ff)), "reverse flag did not toggle")

endmodule

>>> rtl/reversible_deque.sv
// ----------------------------------------------------------------------------
// Reversible deque
// Bounded double-ended queue in a ring store with a front/back reverse flag.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake             Word
//  req      in   req_valid/req_ready   req_word_type (cmd, value)
//  rsp      out  rsp_valid/rsp_ready   rsp_word_type (data, status, count, last)
//
// Push, reverse, clear, ignored codes and commands on an empty deque finish in
// the back-end idle state; a pop or peek of a stored element also passes a
// pop-out state, set by the registered read port of the ring store.
// A dump passes a read and then an emit state for each stored element.
// A word passes the decode stage and command queue, and its response word is
// registered in the back end, after a store read for a pop or peek.
// Reset clears pointers, fill and the reverse flag; the store is not cleared.
// The command queue lets requests keep arriving while responses stall.
module reversible_deque import rdq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic        dec_valid, dec_ready;
   op_word_type dec_word;
   logic        cmd_valid, cmd_ready;
   op_word_type cmd_word;

   // Decode stage.
   rdq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .op_valid  (dec_valid),
      .op_ready  (dec_ready),
      .op_word   (dec_word)
   );

   // Queue of decoded words.
   rdq_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_word   (dec_word),
      .out_valid (cmd_valid),
      .out_ready (cmd_ready),
      .out_word  (cmd_word)
   );

   // Execution and response.
   rdq_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_word  (cmd_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

>>> tb/reversible_deque_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reversible deque regression
// Drives push, pop, peek, reverse, clear, dump and unused command words into
// the deque with random gaps on the request side and random stalls on the
// response side. A tracking model of the ring store, fill and reverse flag
// predicts every response word, and each accepted response is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module reversible_deque_tb;
   import rdq_pkg::*;

   localparam int ITEM_TARGET = 450;
   localparam int SEG_LEN     = 30;
   localparam int IDLE_LIMIT  = 1000;
   localparam int TAIL_CYCLES = 30;

   // Lowest and highest command codes that the deque ignores.
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_DUMP + 4'd1;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

   // Command mixes for the random segments.
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   // Tracks the deque contents and holds the response words still owed.
   class deque_tracker;
      logic [DATA_W-1:0]  ring[DEPTH_DEF];
      logic [5:0]         head;
      logic [COUNT_W-1:0] fill;
      bit                 reversed;
      rsp_word_type       owed_rsp[$];
      int                 mismatches;

      function new();
         head       = '0;
         fill       = '0;
         reversed   = 1'b0;
         mismatches = 0;
      endfunction

      function void add_outcome(logic [DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                                bit last);
         rsp_word_type w;
         w.data   = data;
         w.status = status;
         w.count  = fill;
         w.last   = last;
         owed_rsp = {owed_rsp, w};
      endfunction

      function int outstanding();
         return owed_rsp.size();
      endfunction

      // Applies one accepted request word and queues the responses it causes.
      function void apply_command(req_word_type w);
         bit                phys_front;
         logic [5:0]        slot;
         logic [DATA_W-1:0] d;
         int                n;
         int                off;
         int                i;
         phys_front = (w.cmd[0] == 1'b0) ^ reversed;
         case (w.cmd)
            CMD_PUT_FRONT, CMD_PUT_BACK: begin
               if (fill == COUNT_W'(DEPTH_DEF)) begin
                  add_outcome('0, ST_FULL, 1'b1);
               end else begin
                  if (phys_front) begin
                     head       = head - 6'd1;
                     ring[head] = w.value;
                  end else begin
                     slot       = head + fill[5:0];
                     ring[slot] = w.value;
                  end
                  fill = fill + 1'b1;
                  add_outcome('0, ST_OK, 1'b1);
               end
            end
            CMD_TAKE_FRONT, CMD_TAKE_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
               if (fill == '0) begin
                  add_outcome('0, ST_EMPTY, 1'b1);
               end else begin
                  slot = phys_front ? head : head + fill[5:0] - 6'd1;
                  d    = ring[slot];
                  // Only pops remove the element.
                  if (w.cmd == CMD_TAKE_FRONT || w.cmd == CMD_TAKE_BACK) begin
                     if (phys_front)
                        head = head + 6'd1;
                     fill = fill - 1'b1;
                  end
                  add_outcome(d, ST_OK, 1'b1);
               end
            end
            CMD_REVERSE: begin
               reversed = !reversed;
               add_outcome('0, ST_OK, 1'b1);
            end
            CMD_CLEAR: begin
               fill = '0;
               add_outcome('0, ST_OK, 1'b1);
            end
            CMD_DUMP: begin
               n = fill;
               if (n == 0) begin
                  add_outcome('0, ST_EMPTY, 1'b1);
               end else begin
                  // Every dumped word reports the count after the whole dump.
                  fill = '0;
                  for (i = 0; i < n; i++) begin
                     off  = reversed ? n - 1 - i : i;
                     slot = head + off[5:0];
                     add_outcome(ring[slot], ST_OK, i == n - 1);
                  end
               end
            end
            default: begin
               add_outcome('0, ST_OK, 1'b1);
            end
         endcase
      endfunction

      // Checks one accepted response word against the oldest one owed.
      function void compare_response(rsp_word_type act);
         rsp_word_type exp;
         if (owed_rsp.size() == 0) begin
            $error("unexpected response word: data %0h status %0d count %0d last %0d",
                   act.data, act.status, act.count, act.last);
            mismatches++;
            return;
         end
         exp = owed_rsp[0];
         owed_rsp.delete(0);
         if (act.data !== exp.data) begin
            $error("data: expected %0h, actual %0h", exp.data, act.data);
            mismatches++;
         end
         if (act.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, act.status);
            mismatches++;
         end
         if (act.count !== exp.count) begin
            $error("count: expected %0d, actual %0d", exp.count, act.count);
            mismatches++;
         end
         if (act.last !== exp.last) begin
            $error("last: expected %0d, actual %0d", exp.last, act.last);
            mismatches++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   deque_tracker tracker = new();
   bit           quiet = 1'b0;
   int           words_sent = 0;
   int           idle_cycles = 0;

   reversible_deque DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Gap length: mostly none or short, now and then long; none in quiet stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic req_word_type make_word(logic [CMD_W-1:0] cmd,
                                              logic [VALUE_W-1:0] value);
      req_word_type w;
      w.cmd   = cmd;
      w.value = value;
      return w;
   endfunction

   // Random command drawn from one of the mixes; values are fully random.
   function automatic req_word_type random_command(mix_type mix);
      int               r;
      logic [CMD_W-1:0] cmd;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  r = (r < 70) ? 0 : (r < 80) ? 1 : (r < 86) ? 2 : (r < 90) ? 3 :
                        (r < 93) ? 4 : (r < 95) ? 5 : 6;
         MIX_DRAIN: r = (r < 20) ? 0 : (r < 60) ? 1 : (r < 72) ? 2 : (r < 80) ? 3 :
                        (r < 85) ? 4 : (r < 88) ? 5 : 6;
         default:   r = (r < 42) ? 0 : (r < 65) ? 1 : (r < 77) ? 2 : (r < 85) ? 3 :
                        (r < 89) ? 4 : (r < 92) ? 5 : 6;
      endcase
      case (r)
         0:       cmd = $urandom_range(0, 1) ? CMD_PUT_BACK : CMD_PUT_FRONT;
         1:       cmd = $urandom_range(0, 1) ? CMD_TAKE_BACK : CMD_TAKE_FRONT;
         2:       cmd = $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
         3:       cmd = CMD_REVERSE;
         4:       cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
         5:       cmd = CMD_CLEAR;
         default: cmd = CMD_DUMP;
      endcase
      return make_word(cmd, VALUE_W'($urandom));
   endfunction

   // Sends one request word; entered and left at a falling edge.
   task automatic send_word(req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do
         @(posedge clock);
      while (!req_ready);
      tracker.apply_command(w);
      words_sent++;
      @(negedge clock);
   endtask

   // Holds the request side until every owed response word has arrived.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (tracker.outstanding() != 0);
   endtask

   // Response side: random stalls of random length.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // Check every response word accepted at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.compare_response(rsp_word);
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("reversible_deque regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus.
   initial begin
      int      seg;
      mix_type mix;
      req_valid = 1'b0;
      req_word  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty cases, value extremes, reverse, unused codes, clear.
      send_word(make_word(CMD_PEEK_FRONT, 16'h0000));
      send_word(make_word(CMD_TAKE_BACK, 16'hFFFF));
      send_word(make_word(CMD_DUMP, 16'h0000));
      send_word(make_word(CMD_PUT_BACK, 16'h0000));
      send_word(make_word(CMD_PUT_FRONT, 16'hFFFF));
      send_word(make_word(CMD_PUT_BACK, 16'hA5A5));
      send_word(make_word(CMD_PEEK_FRONT, 16'h0000));
      send_word(make_word(CMD_PEEK_BACK, 16'h0000));
      send_word(make_word(CMD_REVERSE, 16'h0000));
      send_word(make_word(CMD_PEEK_FRONT, 16'h0000));
      send_word(make_word(CMD_TAKE_FRONT, 16'h0000));
      send_word(make_word(CMD_PUT_FRONT, 16'h1234));
      send_word(make_word(CMD_TAKE_BACK, 16'h0000));
      send_word(make_word(CMD_UNUSED_LO, 16'hFFFF));
      send_word(make_word(CMD_UNUSED_HI, 16'h5555));
      send_word(make_word(CMD_PUT_BACK, 16'h5A5A));
      send_word(make_word(CMD_DUMP, 16'h0000));
      send_word(make_word(CMD_REVERSE, 16'h0000));
      send_word(make_word(CMD_PUT_BACK, 16'h8001));
      send_word(make_word(CMD_PUT_FRONT, 16'h7FFE));
      send_word(make_word(CMD_CLEAR, 16'h0000));
      send_word(make_word(CMD_TAKE_FRONT, 16'h0000));
      send_word(make_word(CMD_CLEAR, 16'h0000));
      pause_until_drained();

      // Random segments, two of which fill the deque past full.
      seg = 0;
      while (words_sent < ITEM_TARGET) begin
         mix   = mix_type'($urandom_range(0, 2));
         quiet = ($urandom_range(0, 4) == 0);
         if (seg == 2 || seg == 9) begin
            repeat (DEPTH_DEF + 3)
               send_word(make_word($urandom_range(0, 1) ? CMD_PUT_BACK : CMD_PUT_FRONT,
                                   VALUE_W'($urandom)));
            send_word(make_word(CMD_PEEK_BACK, 16'h0000));
            send_word(make_word(CMD_REVERSE, 16'h0000));
            send_word(make_word(CMD_PUT_FRONT, VALUE_W'($urandom)));
            send_word(make_word(CMD_TAKE_FRONT, 16'h0000));
            send_word(make_word(CMD_DUMP, 16'h0000));
         end
         repeat (SEG_LEN)
            send_word(random_command(mix));
         if (seg == 5)
            pause_until_drained();
         seg++;
      end

      // Drain, then let the pipeline settle.
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("reversible_deque regression: pass");
      else
         $display("reversible_deque regression: fail");
      $finish;
   end

endmodule
